>>> design/ffa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and codes of the free frame allocator
// request and result payloads, status codes and the controller/datapath link
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int FRAME_W = 11;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic               op;
		logic [FRAME_W-1:0] frame_in;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_out;
		logic [1:0]         status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic       load_req;
		logic       do_fresh;
		logic       do_pop;
		logic       do_push;
		logic       load_pop;
		logic       load_err;
		logic [1:0] err_code;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic op;
		logic fresh_avail;
		logic empty;
		logic full;
		logic bad_frame;
	} sts_t;

endpackage

`default_nettype wire

>>> design/ffa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_ctrl: request sequencer
// accepts a request, picks fresh counter, queue pop, push or error, and
// strobes the result for one cycle
// ----------------------------------------------------------------------------
module ffa_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire ffa_pkg::sts_t sts,
	output ffa_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              done
);
	import ffa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECIDE = 4'b0010,
		S_POP    = 4'b0100,
		S_RESP   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.err_code = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_RESP;
				if (sts.op == OP_ALLOC) begin
					// initial fill is used up before the released frames
					if (sts.fresh_avail) begin
						cmd.do_fresh = 1'b1;
					end else if (!sts.empty) begin
						cmd.do_pop = 1'b1;
						state_d    = S_POP;
					end else begin
						cmd.load_err = 1'b1;
						cmd.err_code = ST_EMPTY;
					end
				end else begin
					if (sts.bad_frame) begin
						cmd.load_err = 1'b1;
						cmd.err_code = ST_INVALID;
					end else if (sts.full) begin
						cmd.load_err = 1'b1;
						cmd.err_code = ST_FULL;
					end else begin
						cmd.do_push = 1'b1;
					end
				end
			end
			S_POP: begin
				cmd.load_pop = 1'b1;
				state_d      = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

`default_nettype wire

>>> design/ffa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_datapath: frame pool storage
// frame_count register, fresh counter, queue of released frames with head,
// tail and fill count, and the result register
// ----------------------------------------------------------------------------
module ffa_datapath #(
	parameter int MAX_FRAMES = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire ffa_pkg::req_t                req,
	input  wire ffa_pkg::cmd_t                cmd,
	input  wire logic                         cfg_we,
	input  wire logic [ffa_pkg::FRAME_W-1:0]  cfg_data,
	output ffa_pkg::sts_t                     sts,
	output ffa_pkg::rsp_t                     rsp
);
	import ffa_pkg::*;

	localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW = $clog2(MAX_FRAMES + 1);

	logic [FRAME_W-1:0] mem [MAX_FRAMES];

	req_t               req_q;
	rsp_t               rsp_q;
	logic [FRAME_W-1:0] frame_count_q;
	logic [FRAME_W-1:0] fresh_q;
	logic [FRAME_W-1:0] rd_q;
	logic [IW-1:0]      head_q, tail_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      head_nxt, tail_nxt;

	// positions wrap at the store depth, which need not be a power of two
	assign head_nxt = (head_q == IW'(MAX_FRAMES - 1)) ? '0 : head_q + IW'(1);
	assign tail_nxt = (tail_q == IW'(MAX_FRAMES - 1)) ? '0 : tail_q + IW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_W'(1024);
			fresh_q       <= FRAME_W'(1);
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
		end else begin
			if (cfg_we) begin
				frame_count_q <= cfg_data;
			end
			if (cmd.do_fresh) begin
				fresh_q <= fresh_q + FRAME_W'(1);
			end
			if (cmd.do_pop) begin
				head_q  <= head_nxt;
				count_q <= count_q - CW'(1);
			end
			if (cmd.do_push) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_push) begin
			mem[tail_q] <= req_q.frame_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_pop) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_fresh) begin
			rsp_q.frame_out <= fresh_q;
			rsp_q.status    <= ST_OK;
		end else if (cmd.do_push) begin
			rsp_q.frame_out <= '0;
			rsp_q.status    <= ST_OK;
		end else if (cmd.load_err) begin
			rsp_q.frame_out <= '0;
			rsp_q.status    <= cmd.err_code;
		end else if (cmd.load_pop) begin
			rsp_q.frame_out <= rd_q;
			rsp_q.status    <= ST_OK;
		end
	end

	assign sts.op          = req_q.op;
	assign sts.fresh_avail = (fresh_q < frame_count_q);
	assign sts.empty       = (count_q == '0);
	assign sts.full        = (count_q == CW'(MAX_FRAMES));
	assign sts.bad_frame   = (req_q.frame_in == '0) || (req_q.frame_in > frame_count_q);

	assign rsp = rsp_q;

endmodule

`default_nettype wire

>>> design/free_frame_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// free_frame_allocator_core: FIFO pool of free page frames
// hands out the oldest free frame on allocate and queues frames on release
// ----------------------------------------------------------------------------
// usage:
//   a request (op, frame_in) is taken when start is high and busy is low.
//   op allocate returns the oldest free frame, or frame 0 with status empty;
//   op release queues frame_in, or reports invalid frame or pool full.
//   the result sits on rsp for exactly one cycle with done high; the
//   receiver must take it then, it cannot stall the block.
//   from accept to done the controller steps through decide and result,
//   and an allocate that pops the released-frame queue adds a pop step for
//   the registered memory read. one request is handled at a time; a new
//   one is taken only once busy is low again after the result.
//   frame_count is written through cfg_valid/cfg_data while idle; cfg_ready
//   is low while a request is in flight or offered on start.
//   reset: the pool holds frames 1 to frame_count-1 in ascending order, the
//   queue of released frames is empty and frame_count is 1024. no clearing
//   pass is needed, the block takes requests straight after reset.
// ----------------------------------------------------------------------------
module free_frame_allocator_core #(
	parameter int MAX_FRAMES = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire ffa_pkg::req_t               req,
	output logic                             done,
	output ffa_pkg::rsp_t                    rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [ffa_pkg::FRAME_W-1:0] cfg_data
);
	import ffa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// a request offered on start takes precedence over a register write
	assign cfg_ready = !busy && !start;

	ffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ffa_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.sts      (sts),
		.rsp      (rsp)
	);

	// a result only comes while a request is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// block is free again right after the result
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("still busy after result");

	// an accepted request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// error results never carry a frame
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.frame_out == '0))
		else $error("error result with a frame number");

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: free_frame_allocator_core
// a directed table, then random allocate and release traffic under several
// frame counts; a response is checked against the table's value if the row
// gives one, else against a cycle-free model of the frame pool in the bench
// ----------------------------------------------------------------------------
module testbench;
	import ffa_pkg::*;

	localparam int MAX_FRAMES  = 1024;
	localparam int QUIET_LIMIT = 2000;
	localparam int MIX_ITEMS   = 95;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               op;
		logic [FRAME_W-1:0] value;
		logic               typed;
		rsp_t               want;
	} plan_row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	req_t               req       = '0;
	logic               cfg_valid = 1'b0;
	logic [FRAME_W-1:0] cfg_data  = '0;
	logic               busy;
	logic               done;
	rsp_t               rsp;
	logic               cfg_ready;

	// model of the pool
	logic [FRAME_W-1:0] pool_limit = 11'd1024;
	logic [FRAME_W-1:0] fill_next  = 11'd1;
	logic [FRAME_W-1:0] freed_q [MAX_FRAMES];
	logic [9:0]         rd_ptr     = '0;
	logic [9:0]         wr_ptr     = '0;
	logic [FRAME_W-1:0] freed_n    = '0;

	rsp_t answers_due [$];
	int   errors  = 0;
	int   gap_pct = 11;
	int   quiet   = 0;

	logic [FRAME_W-1:0] mix_limits [8] = '{11'd1024, 11'd1, 11'd700, 11'd3,
		11'd1023, 11'd17, 11'd512, 11'd2};

	plan_row_t plan [23] = '{
		'{ROW_REQ, OP_ALLOC,   11'd0,    1'b1, '{11'd1, ST_OK}},
		'{ROW_REQ, OP_ALLOC,   11'd1024, 1'b1, '{11'd2, ST_OK}},
		'{ROW_REQ, OP_RELEASE, 11'd0,    1'b1, '{11'd0, ST_INVALID}},
		'{ROW_REQ, OP_RELEASE, 11'd1024, 1'b1, '{11'd0, ST_OK}},
		'{ROW_REQ, OP_RELEASE, 11'd1023, 1'b1, '{11'd0, ST_OK}},
		'{ROW_REQ, OP_RELEASE, 11'd7,    1'b0, '0},
		'{ROW_REQ, OP_RELEASE, 11'd7,    1'b0, '0},
		'{ROW_CFG, OP_ALLOC,   11'd1,    1'b0, '0},
		'{ROW_REQ, OP_RELEASE, 11'd2,    1'b1, '{11'd0, ST_INVALID}},
		'{ROW_REQ, OP_RELEASE, 11'd1,    1'b1, '{11'd0, ST_OK}},
		'{ROW_REQ, OP_ALLOC,   11'd5,    1'b0, '0},
		'{ROW_REQ, OP_ALLOC,   11'd0,    1'b0, '0},
		'{ROW_REQ, OP_ALLOC,   11'd0,    1'b0, '0},
		'{ROW_REQ, OP_ALLOC,   11'd0,    1'b0, '0},
		'{ROW_REQ, OP_ALLOC,   11'd0,    1'b0, '0},
		'{ROW_REQ, OP_ALLOC,   11'd0,    1'b1, '{11'd0, ST_EMPTY}},
		'{ROW_CFG, OP_ALLOC,   11'd1024, 1'b0, '0},
		'{ROW_REQ, OP_ALLOC,   11'd0,    1'b0, '0},
		'{ROW_REQ, OP_RELEASE, 11'd1024, 1'b0, '0},
		'{ROW_CFG, OP_ALLOC,   11'd5,    1'b0, '0},
		'{ROW_REQ, OP_ALLOC,   11'd0,    1'b0, '0},
		'{ROW_REQ, OP_ALLOC,   11'd0,    1'b0, '0},
		'{ROW_REQ, OP_ALLOC,   11'd0,    1'b0, '0}
	};

	free_frame_allocator_core #(
		.MAX_FRAMES(MAX_FRAMES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t pool_answer(req_t r);
		rsp_t a;
		a = '{frame_out: '0, status: ST_OK};
		if (r.op == OP_ALLOC) begin
			// the initial fill is used up before the queue of released frames
			if (fill_next < pool_limit) begin
				a.frame_out = fill_next;
				fill_next++;
			end else if (freed_n != 0) begin
				a.frame_out = freed_q[rd_ptr];
				rd_ptr++;
				freed_n--;
			end else begin
				a.status = ST_EMPTY;
			end
		end else if (r.frame_in == 0 || r.frame_in > pool_limit) begin
			a.status = ST_INVALID;
		end else if (freed_n >= MAX_FRAMES) begin
			a.status = ST_FULL;
		end else begin
			freed_q[wr_ptr] = r.frame_in;
			wr_ptr++;
			freed_n++;
		end
		return a;
	endfunction

	task automatic send_req(req_t r, logic typed, rsp_t want);
		rsp_t predicted;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = pool_answer(r);
		answers_due.push_back(typed ? want : predicted);
	endtask

	// only written once every response is in, so the block is idle
	task automatic set_frame_count(logic [FRAME_W-1:0] n);
		start <= 1'b0;
		do @(posedge clk); while (answers_due.size() != 0);
		cfg_valid <= 1'b1;
		cfg_data  <= n;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		pool_limit = n;
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (answers_due.size() == 0) begin
				$error("unexpected response: frame_out %0d status %0d", rsp.frame_out, rsp.status);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (rsp.frame_out !== want.frame_out) begin
					$error("frame_out: expected %0d, got %0d", want.frame_out, rsp.frame_out);
					errors++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					errors++;
				end
			end
		end
	end

	// counts cycles with no request, response or register write
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet++;
		end
	end

	initial begin
		req_t r;
		int   pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				set_frame_count(plan[i].value);
			end else begin
				r.op       = plan[i].op;
				r.frame_in = plan[i].value;
				send_req(r, plan[i].typed, plan[i].want);
			end
		end

		foreach (mix_limits[p]) begin
			gap_pct = (p < 3) ? 11 : (p < 6) ? 49 : 0;
			set_frame_count(mix_limits[p]);
			repeat (MIX_ITEMS) begin
				if ($urandom_range(1) == 0) begin
					r.op       = OP_ALLOC;
					r.frame_in = FRAME_W'($urandom_range(1024, 0));
				end else begin
					r.op = OP_RELEASE;
					pick = $urandom_range(99);
					if (pick < 8)
						r.frame_in = '0;
					else if (pick < 16 && pool_limit < 1024)
						r.frame_in = FRAME_W'($urandom_range(1024, pool_limit + 1));
					else if (pick < 24)
						r.frame_in = pool_limit;
					else
						r.frame_in = FRAME_W'($urandom_range(pool_limit, 1));
				end
				send_req(r, 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> free_frame_allocator_core.f
design/ffa_pkg.sv
design/ffa_ctrl.sv
design/ffa_datapath.sv
design/free_frame_allocator_core.sv
sim/testbench.sv
